[hw/rtl/dfr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfr_pkg
// Shared constants, types and the divider step for the dielectric Fresnel
// reflectance pipeline.
// ----------------------------------------------------------------------------
package dfr_pkg;

	// Fixed-point formats of the ports and of the internal datapath.
	localparam int COS_FRAC_BITS = 15;
	localparam int OUT_FRAC_BITS = 16;
	localparam int INT_BITS      = 30;

	// Iteration counts of the serial units, one stage per step.
	localparam int DIV_STEPS  = INT_BITS;
	localparam int SQRT_STEPS = INT_BITS + 1;
	localparam int RDIV_STEPS = INT_BITS;

	// Per-item values that ride alongside the arithmetic.
	typedef struct packed {
		logic [15:0] mag;
		logic [15:0] eta_i;
		logic [15:0] eta_t;
		logic        tir;
	} side_t;

	// One restoring division step: shifts one dividend bit into the remainder
	// and returns the quotient bit above the new remainder.
	function automatic logic [32:0] div_step(input logic [31:0] rem, input logic din,
		input logic [31:0] dvsr);
		logic [32:0] t;
		logic [32:0] d;
		logic [32:0] res;
		t = {rem, din};
		d = {1'b0, dvsr};
		if (t >= d) begin
			res = {1'b1, 32'(t - d)};
		end else begin
			res = {1'b0, t[31:0]};
		end
		return res;
	endfunction

endpackage

[hw/rtl/dielectric_fresnel_reflectance.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dielectric_fresnel_reflectance
// Unpolarized Fresnel reflectance at a dielectric boundary, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: cos_incident (Q1.15, signed), eta_incident and
//   eta_transmitted (unsigned Q4.12) move on in_valid / in_stall.
//   Output channel: reflectance (Q1.16, 65536 is one) and total_internal move
//   on out_valid / out_stall. Every input transfer yields one output transfer,
//   in order.
//   One item enters in every cycle while in_stall is low; the depth is set by
//   the serial units, one bit per stage: the 30-step sine divider, the
//   31-step square root and the two 30-step amplitude-ratio dividers running
//   side by side.
//   The whole pipeline advances as one; when the output holds an item and the
//   receiver stalls, every stage freezes and in_stall is raised, so nothing is
//   lost or repeated.
//   Reset clears all valid bits; the pipeline then accepts at once.
// ----------------------------------------------------------------------------
module dielectric_fresnel_reflectance (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] cos_incident,
	input  logic [15:0] eta_incident,
	input  logic [15:0] eta_transmitted,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [16:0] reflectance,
	output logic        total_internal
);

	localparam int DN = dfr_pkg::DIV_STEPS;
	localparam int SN = dfr_pkg::SQRT_STEPS;
	localparam int RN = dfr_pkg::RDIV_STEPS;
	localparam int IB = dfr_pkg::INT_BITS;
	localparam logic [31:0] ONE_Q = 32'(64'd1 << IB);
	localparam logic [16:0] REFL_ONE = 17'(64'd1 << dfr_pkg::OUT_FRAC_BITS);

	logic adv;

	// Global advance: the output stage is free or being taken.
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// ---------------- Stage 1: side select, magnitude, squares ----------------
	logic signed [15:0] cos_s;
	logic               cos_pos;
	logic [16:0]        mag_w;
	logic [15:0]        mag_c;
	logic [15:0]        ei_c;
	logic [15:0]        et_c;
	logic [31:0]        mm_c;

	// The 16-bit cosine never leaves [-1,1], so the clamp is a no-op here.
	always_comb begin
		cos_s   = signed'(cos_incident);
		cos_pos = cos_s > 16'sd0;
		mag_w   = cos_pos ? {1'b0, cos_incident} : 17'(-{cos_incident[15], cos_incident});
		mag_c   = mag_w[15:0];
		ei_c    = cos_pos ? eta_incident : eta_transmitted;
		et_c    = cos_pos ? eta_transmitted : eta_incident;
		mm_c    = 32'(mag_c) * 32'(mag_c);
	end

	logic        vld_s1;
	logic [15:0] mag_s1, ei_s1, et_s1;
	logic [31:0] ei2_s1, et2_s1;
	logic [30:0] sin2_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s1  <= mag_c;
			ei_s1   <= ei_c;
			et_s1   <= et_c;
			ei2_s1  <= 32'(ei_c) * 32'(ei_c);
			et2_s1  <= 32'(et_c) * 32'(et_c);
			sin2_s1 <= 31'(ONE_Q - mm_c);
		end
	end

	// ---------------- Stage 2: scaled incident side ----------------
	logic        vld_s2;
	logic [15:0] mag_s2, ei_s2, et_s2;
	logic [31:0] et2_s2;
	logic [62:0] lhs_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s2 <= mag_s1;
			ei_s2  <= ei_s1;
			et_s2  <= et_s1;
			et2_s2 <= et2_s1;
			lhs_s2 <= 63'(ei2_s1) * 63'(sin2_s1);
		end
	end

	// ---------------- Stage 3: total reflection test, divider setup ----------------
	logic              div_vld_s [DN+1];
	dfr_pkg::side_t    div_side_s [DN+1];
	logic [31:0]       div_dvsr_s [DN+1];
	logic [31:0]       div_rem_s [DN+1];
	logic [IB-1:0]     div_low_s [DN+1];
	logic [IB-1:0]     div_q_s [DN+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_vld_s[0] <= 1'b0;
		end else if (adv) begin
			div_vld_s[0] <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_side_s[0] <= '{mag: mag_s2, eta_i: ei_s2, eta_t: et_s2,
				tir: lhs_s2 >= {1'b0, et2_s2, 30'b0}};
			div_dvsr_s[0] <= et2_s2;
			div_rem_s[0]  <= lhs_s2[61:30];
			div_low_s[0]  <= lhs_s2[IB-1:0];
			div_q_s[0]    <= '0;
		end
	end

	// ---------------- Transmitted squared sine divider ----------------
	for (genvar g = 0; g < DN; g++) begin : g_div
		logic [32:0] st;
		assign st = dfr_pkg::div_step(div_rem_s[g], div_low_s[g][IB-1], div_dvsr_s[g]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s[g+1] <= 1'b0;
			end else if (adv) begin
				div_vld_s[g+1] <= div_vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_side_s[g+1] <= div_side_s[g];
				div_dvsr_s[g+1] <= div_dvsr_s[g];
				div_rem_s[g+1]  <= st[31:0];
				div_low_s[g+1]  <= {div_low_s[g][IB-2:0], 1'b0};
				div_q_s[g+1]    <= {div_q_s[g][IB-2:0], st[32]};
			end
		end
	end

	// ---------------- Stage 4: square root setup ----------------
	logic              sq_vld_s [SN+1];
	dfr_pkg::side_t    sq_side_s [SN+1];
	logic [61:0]       sq_v_s [SN+1];
	logic [32:0]       sq_rem_s [SN+1];
	logic [30:0]       sq_root_s [SN+1];
	logic [30:0]       cos2_c;

	assign cos2_c = 31'(ONE_Q - {2'b0, div_q_s[DN]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_vld_s[0] <= 1'b0;
		end else if (adv) begin
			sq_vld_s[0] <= div_vld_s[DN];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_side_s[0] <= div_side_s[DN];
			sq_v_s[0]    <= {1'b0, cos2_c, 30'b0};
			sq_rem_s[0]  <= '0;
			sq_root_s[0] <= '0;
		end
	end

	// ---------------- Transmitted cosine square root, two bits per stage ----------------
	for (genvar g = 0; g < SN; g++) begin : g_sqrt
		logic [34:0] t;
		logic [34:0] trial;
		assign t     = {sq_rem_s[g], sq_v_s[g][61:60]};
		assign trial = {2'b0, sq_root_s[g], 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld_s[g+1] <= 1'b0;
			end else if (adv) begin
				sq_vld_s[g+1] <= sq_vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_side_s[g+1] <= sq_side_s[g];
				sq_v_s[g+1]    <= {sq_v_s[g][59:0], 2'b00};
				if (t >= trial) begin
					sq_rem_s[g+1]  <= 33'(t - trial);
					sq_root_s[g+1] <= {sq_root_s[g][29:0], 1'b1};
				end else begin
					sq_rem_s[g+1]  <= t[32:0];
					sq_root_s[g+1] <= {sq_root_s[g][29:0], 1'b0};
				end
			end
		end
	end

	// ---------------- Stage 5: amplitude products, lane 0 parallel, lane 1 perpendicular ----
	logic        vld_s5;
	logic        tir_s5;
	logic [46:0] a_s5 [2];
	logic [46:0] b_s5 [2];
	logic [30:0] cos_q_c;
	dfr_pkg::side_t sd_c;

	assign sd_c    = sq_side_s[SN];
	assign cos_q_c = {sd_c.mag, 15'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= sq_vld_s[SN];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tir_s5  <= sd_c.tir;
			a_s5[0] <= 47'(sd_c.eta_t) * 47'(cos_q_c);
			b_s5[0] <= 47'(sd_c.eta_i) * 47'(sq_root_s[SN]);
			a_s5[1] <= 47'(sd_c.eta_i) * 47'(cos_q_c);
			b_s5[1] <= 47'(sd_c.eta_t) * 47'(sq_root_s[SN]);
		end
	end

	// ---------------- Stage 6: difference and sum ----------------
	logic        vld_s6;
	logic        tir_s6;
	logic [46:0] num_s6 [2];
	logic [47:0] den_s6 [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tir_s6 <= tir_s5;
			for (int l = 0; l < 2; l++) begin
				num_s6[l] <= (a_s5[l] > b_s5[l]) ? a_s5[l] - b_s5[l] : b_s5[l] - a_s5[l];
				den_s6[l] <= 48'(a_s5[l]) + 48'(b_s5[l]);
			end
		end
	end

	// ---------------- Stage 7: scale the pair down below 2^32 ----------------
	logic [4:0]  shamt_c [2];

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			shamt_c[l] = '0;
			for (int k = 0; k < 16; k++) begin
				if (den_s6[l][32+k]) begin
					shamt_c[l] = 5'(k + 1);
				end
			end
		end
	end

	logic        vld_s7;
	logic        tir_s7;
	logic [1:0]  zero_s7;
	logic [31:0] num_s7 [2];
	logic [31:0] den_s7 [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tir_s7 <= tir_s6;
			for (int l = 0; l < 2; l++) begin
				zero_s7[l] <= den_s6[l] == '0;
				num_s7[l]  <= 32'(num_s6[l] >> shamt_c[l]);
				den_s7[l]  <= 32'(den_s6[l] >> shamt_c[l]);
			end
		end
	end

	// ---------------- Stage 8: ratio divider setup (integer bit) ----------------
	logic        rd_vld_s [RN+1];
	logic        rd_tir_s [RN+1];
	logic [1:0]  rd_zero_s [RN+1];
	logic [31:0] rd_dvsr_s [RN+1][2];
	logic [31:0] rd_rem_s [RN+1][2];
	logic [30:0] rd_q_s [RN+1][2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s[0] <= 1'b0;
		end else if (adv) begin
			rd_vld_s[0] <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rd_tir_s[0]  <= tir_s7;
			rd_zero_s[0] <= zero_s7;
			for (int l = 0; l < 2; l++) begin
				rd_dvsr_s[0][l] <= den_s7[l];
				if (num_s7[l] >= den_s7[l]) begin
					rd_rem_s[0][l] <= num_s7[l] - den_s7[l];
					rd_q_s[0][l]   <= 31'd1;
				end else begin
					rd_rem_s[0][l] <= num_s7[l];
					rd_q_s[0][l]   <= 31'd0;
				end
			end
		end
	end

	// ---------------- Amplitude ratio dividers, two lanes ----------------
	for (genvar g = 0; g < RN; g++) begin : g_rdiv
		logic [32:0] st [2];
		for (genvar l = 0; l < 2; l++) begin : g_lane
			assign st[l] = dfr_pkg::div_step(rd_rem_s[g][l], 1'b0, rd_dvsr_s[g][l]);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rd_vld_s[g+1] <= 1'b0;
			end else if (adv) begin
				rd_vld_s[g+1] <= rd_vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rd_tir_s[g+1]  <= rd_tir_s[g];
				rd_zero_s[g+1] <= rd_zero_s[g];
				for (int l = 0; l < 2; l++) begin
					rd_dvsr_s[g+1][l] <= rd_dvsr_s[g][l];
					rd_rem_s[g+1][l]  <= st[l][31:0];
					rd_q_s[g+1][l]    <= {rd_q_s[g][l][29:0], st[l][32]};
				end
			end
		end
	end

	// ---------------- Stage 9: squared ratios ----------------
	logic        vld_s9;
	logic        tir_s9;
	logic [1:0]  zero_s9;
	logic [61:0] sq_s9 [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else if (adv) begin
			vld_s9 <= rd_vld_s[RN];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tir_s9  <= rd_tir_s[RN];
			zero_s9 <= rd_zero_s[RN];
			for (int l = 0; l < 2; l++) begin
				sq_s9[l] <= 62'(rd_q_s[RN][l]) * 62'(rd_q_s[RN][l]);
			end
		end
	end

	// ---------------- Stage 10: mean, saturation, output register ----------------
	logic [30:0] rsq_c [2];
	logic [31:0] sum_c;
	logic [30:0] mean_c;
	logic [16:0] refl_c;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			rsq_c[l] = zero_s9[l] ? ONE_Q[30:0] : sq_s9[l][60:30];
		end
		sum_c  = 32'(rsq_c[0]) + 32'(rsq_c[1]);
		mean_c = sum_c[31:1];
		refl_c = 17'(mean_c >> (IB - dfr_pkg::OUT_FRAC_BITS));
		if (tir_s9 || refl_c > REFL_ONE) begin
			refl_c = REFL_ONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			reflectance    <= refl_c;
			total_internal <= tir_s9;
		end
	end

endmodule

[hw/rtl/dfr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfr_checker
// Port-level checks of the reflectance pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module dfr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [16:0] reflectance,
	input logic        total_internal
);

	localparam logic [16:0] REFL_ONE = 17'(64'd1 << dfr_pkg::OUT_FRAC_BITS);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its value.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(reflectance) && $stable(total_internal))
		else $error("result changed while stalled");

	// The input side stalls exactly when a waiting result is stalled.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not follow output backpressure");

	// Total reflection always reports one.
	a_tir_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && total_internal |-> reflectance == REFL_ONE)
		else $error("total reflection without unit reflectance");

	// Reflectance never exceeds one.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> reflectance <= REFL_ONE)
		else $error("reflectance above one");

endmodule

bind dielectric_fresnel_reflectance dfr_checker u_dfr_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.reflectance    (reflectance),
	.total_internal (total_internal)
);

[sim/tb_dielectric_fresnel_reflectance.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dielectric_fresnel_reflectance
// Drives incident cosines and index pairs into the Fresnel pipeline and checks
// every reflectance and total-internal flag against a fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_dielectric_fresnel_reflectance;

	localparam int LATENCY = 101;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [15:0] cos_incident;
	logic [15:0] eta_incident;
	logic [15:0] eta_transmitted;
	logic        out_valid;
	logic        out_stall;
	logic [16:0] reflectance;
	logic        total_internal;

	typedef struct packed {
		logic [16:0] refl;
		logic        tir;
	} fresnel_t;

	fresnel_t expected_q[$];
	int  error_count = 0;
	int  sent_count = 0;
	int  tir_count = 0;
	int  checked_count = 0;
	bit  in_idle_en = 1;
	bit  out_idle_en = 1;

	dielectric_fresnel_reflectance uut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.cos_incident(cos_incident), .eta_incident(eta_incident),
		.eta_transmitted(eta_transmitted), .out_valid(out_valid),
		.out_stall(out_stall), .reflectance(reflectance),
		.total_internal(total_internal)
	);

	// Clock with a 20 ns period.
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Bitwise integer square root, floor.
	function automatic logic [63:0] isqrt(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// Squared amplitude ratio ((a-b)/(a+b))^2 in Q30.
	function automatic logic [63:0] amp_ratio_sq(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] r;
		num = (a > b) ? a - b : b - a;
		den = a + b;
		if (den == 0) return 64'd1 << 30;
		while (den >= (64'd1 << 32)) begin
			den >>= 1;
			num >>= 1;
		end
		r = (num << 30) / den;
		return (r * r) >> 30;
	endfunction

	// Predicts reflectance and flag for one incident cosine and index pair.
	function automatic fresnel_t predict_fresnel(input logic [15:0] cos_raw,
		input logic [15:0] ei_raw, input logic [15:0] et_raw);
		fresnel_t    res;
		longint      cosv;
		logic [63:0] eta_i, eta_t, tmp, c, s2, lhs, rhs, st2, ct, rpa, rpe, refl;
		cosv = longint'($signed(cos_raw));
		eta_i = ei_raw;
		eta_t = et_raw;
		if (cosv > 32768) cosv = 32768;
		if (cosv < -32768) cosv = -32768;
		// A non-positive cosine means arrival from the far side.
		if (!(cosv > 0)) begin
			tmp = eta_i;
			eta_i = eta_t;
			eta_t = tmp;
			cosv = -cosv;
		end
		c = 64'(cosv) << 15;
		s2 = ((64'd1 << 60) - c * c) >> 30;
		lhs = eta_i * eta_i * s2;
		rhs = (eta_t * eta_t) << 30;
		if (lhs >= rhs) begin
			res.refl = 17'h10000;
			res.tir = 1'b1;
			return res;
		end
		st2 = lhs / (eta_t * eta_t);
		ct = isqrt(((64'd1 << 30) - st2) << 30);
		rpa = amp_ratio_sq(eta_t * c, eta_i * ct);
		rpe = amp_ratio_sq(eta_i * c, eta_t * ct);
		refl = ((rpa + rpe) >> 1) >> 14;
		if (refl > 64'h10000) refl = 64'h10000;
		res.refl = refl[16:0];
		res.tir = 1'b0;
		return res;
	endfunction

	// Sends one item and records its expected result once the transfer occurs.
	// Valid stays high afterwards so that items can follow back to back.
	task automatic send_item(input logic [15:0] cv, input logic [15:0] ei,
		input logic [15:0] et);
		int gap;
		if (in_idle_en && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 10);
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		cos_incident <= cv;
		eta_incident <= ei;
		eta_transmitted <= et;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_q.push_back(predict_fresnel(cv, ei, et));
		sent_count++;
		@(negedge clk);
	endtask

	// Drops valid once a sequence of items is over.
	task automatic stop_input();
		in_valid <= 1'b0;
	endtask

	// Receiver stall in random bursts.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (out_idle_en && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 10)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Compares every output transfer with the oldest expectation.
	always @(posedge clk) begin
		fresnel_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$error("unexpected transfer: reflectance %0d total_internal %0b",
					reflectance, total_internal);
				error_count++;
			end else begin
				want = expected_q.pop_front();
				checked_count++;
				if (want.tir) tir_count++;
				if (reflectance !== want.refl) begin
					$error("reflectance: expected %0d, actual %0d", want.refl, reflectance);
					error_count++;
				end
				if (total_internal !== want.tir) begin
					$error("total_internal: expected %0b, actual %0b", want.tir,
						total_internal);
					error_count++;
				end
			end
		end
	end

	function automatic logic [15:0] rand_eta();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(4096, 12288));
			1: return 16'($urandom_range(1024, 65535));
			2: return 16'($urandom_range(0, 1023));
			default: return 16'($urandom);
		endcase
	endfunction

	// Extremes of every field and the named special cases.
	task automatic test_directed();
		send_item(16'h7FFF, 16'd4096, 16'd6144);
		send_item(16'h8000, 16'd4096, 16'd6144);
		send_item(16'h8001, 16'd6144, 16'd4096);
		send_item(16'h0000, 16'd4096, 16'd6144);
		send_item(16'h0001, 16'd6144, 16'd4096);
		send_item(16'hFFFF, 16'd6144, 16'd4096);
		send_item(16'h4000, 16'd6144, 16'd4096);
		send_item(16'h2000, 16'd6144, 16'd4096);
		send_item(16'h4000, 16'd4096, 16'd4096);
		send_item(16'h4000, 16'd1024, 16'd65535);
		send_item(16'h4000, 16'd65535, 16'd1024);
		send_item(16'h4000, 16'd65535, 16'd65535);
		send_item(16'h4000, 16'd5000, 16'd0);
		send_item(16'hC000, 16'd0, 16'd5000);
		send_item(16'h4000, 16'd0, 16'd0);
		send_item(16'h7FFF, 16'd0, 16'd0);
		send_item(16'h4000, 16'd0, 16'd5000);
		send_item(16'h4000, 16'd500, 16'd300);
		send_item(16'hAAAA, 16'h5555, 16'hAAAA);
		send_item(16'h5555, 16'hAAAA, 16'h5555);
	endtask

	// Random cosines and indices, mostly in physical ranges.
	task automatic test_random(input int count);
		logic [15:0] cv;
		repeat (count) begin
			cv = ($urandom_range(0, 4) == 0) ? 16'($urandom)
				: 16'($urandom_range(0, 32768) - (($urandom_range(0, 1) == 1) ? 32768 : 0));
			send_item(cv, rand_eta(), rand_eta());
		end
	endtask

	// Sender holds off until the pipeline has drained.
	task automatic test_drain_pause();
		stop_input();
		while (expected_q.size() != 0) @(negedge clk);
		test_random(20);
	endtask

	// Back to back with no idling on either side.
	task automatic test_full_rate();
		in_idle_en = 0;
		out_idle_en = 0;
		test_random(100);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		cos_incident = 16'h0;
		eta_incident = 16'h0;
		eta_transmitted = 16'h0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(360);
		test_drain_pause();
		test_full_rate();
		stop_input();
		while (expected_q.size() != 0) @(negedge clk);
		repeat (LATENCY + 20) @(negedge clk);
		$display("Sent %0d items, checked %0d results, %0d with total reflection.",
			sent_count, checked_count, tir_count);
		if (error_count == 0 && expected_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Run limit.
	initial begin
		#2ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule
